FILE: hdl/sqvg_pkg.sv
// Shared types, constants and the quarter-wave sine table for the sprite quad generator.
package sqvg_pkg;

    localparam int ANGLE_BITS  = 10;
    localparam int MAX_FRAMES  = 4096;
    localparam int QUARTER_N   = 1 << (ANGLE_BITS - 2);
    localparam int TRIG_W      = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 34;
    localparam int FRAC_SHIFT  = 14;
    localparam int DIV_NW      = 25;
    localparam int UV_W        = 17;
    localparam int ATLAS_MAX   = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRITE_WIDTH  = 3'd0,
        REG_SPRITE_HEIGHT = 3'd1,
        REG_FRAMES_ACROSS = 3'd2,
        REG_FRAMES_DOWN   = 3'd3,
        REG_FRAME_COUNT   = 3'd4,
        REG_ANIM_ENABLE   = 3'd5,
        REG_FRAME_HOLD    = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DIV_STEP,
        DIV_COLQ,
        DIV_ROW,
        DIV_U0,
        DIV_U1,
        DIV_V0,
        DIV_V1
    } div_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SIN,
        ST_COS,
        ST_MUL,
        ST_CORNER
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       tick;
        logic       div_start;
        logic       div_capture;
        div_op_t    div_op;
        logic       trig_load;
        logic       trig_cos;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       emit;
        logic [1:0] corner;
    } sqvg_cmd_t;

    typedef struct packed {
        logic step_due;
        logic uv_dirty;
        logic div_done;
        logic out_busy;
    } sqvg_status_t;

    typedef logic [14:0] sine_tab_t [0:QUARTER_N];

    // Shift-and-subtract long division, used while the table is built
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Taylor series of sin over a quarter wave in Q30, rounded half up to Q14
    function automatic sine_tab_t sine_table_build();
        sine_tab_t       t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint          sum;
        for (int r = 0; r <= QUARTER_N; r++)
        begin
            x    = (PI_HALF_Q30 * longint'(r)) >> (ANGLE_BITS - 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 7; n++)
            begin
                den  = longint'((2 * n) * (2 * n + 1));
                term = udiv64((term * x2) >> 30, den);
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 32768) / 65536;
            if (sum > 16384)
                sum = 16384;
            t[r] = 15'(sum);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TABLE = sine_table_build();

endpackage

FILE: hdl/sprite_quad_vertex_generator.sv
// Top level of the sprite quad vertex generator: controller plus datapath.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata: centre x, centre y, angle, advance
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata: corner, x, y, u, v; tlast
//  cfg       in   cfg_wr_en                        cfg_index, cfg_data
//
// One item gives four corner transfers. With cached UVs an item passes through accept,
// tick, sin, cos, four products on the one shared multiplier and four corners.
// After reset, a config write or a frame step the atlas UVs are refreshed by the
// bit-serial divider first: 6 divisions, plus one more for a frame step.
// Reset clears state; the UV cache is marked stale, so the first item pays the refresh.
// A stalled output holds the corner sequence; the next item is taken once the
// fourth corner sits in the output register.
module sprite_quad_vertex_generator #(
    parameter int MAX_FRAMES = sqvg_pkg::MAX_FRAMES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [47:0]                     s_axis_tdata,  // center_x, center_y, angle, advance
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [71:0]                     m_axis_tdata,  // corner, vertex_x, vertex_y, tex_u, tex_v
    output logic                            m_axis_tlast,
    input  logic                            cfg_wr_en,
    input  logic [sqvg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sqvg_pkg::CFG_DATA_W-1:0] cfg_data
);

    sqvg_pkg::sqvg_cmd_t    cmd;
    sqvg_pkg::sqvg_status_t status;

    logic [1:0]                 corner;
    logic signed [15:0]         vx, vy;
    logic [sqvg_pkg::UV_W-1:0]  tu, tv;

    sqvg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sqvg_datapath #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .center_x     (s_axis_tdata[15:0]),
        .center_y     (s_axis_tdata[31:16]),
        .angle        (s_axis_tdata[41:32]),
        .advance      (s_axis_tdata[42]),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_corner   (corner),
        .out_vertex_x (vx),
        .out_vertex_y (vy),
        .out_tex_u    (tu),
        .out_tex_v    (tv),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, tv, tu, vy, vx, corner};

endmodule

FILE: hdl/sqvg_divider.sv
// Restoring divider, one quotient bit per cycle.
module sqvg_divider #(
    parameter int NW = sqvg_pkg::DIV_NW,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/sqvg_datapath.sv
// Datapath: config registers, animation state, atlas UVs, rotation and corner output.
module sqvg_datapath #(
    parameter int MAX_FRAMES = sqvg_pkg::MAX_FRAMES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sqvg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sqvg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [15:0]             center_x,
    input  logic signed [15:0]             center_y,
    input  logic [9:0]                     angle,
    input  logic                           advance,
    input  sqvg_pkg::sqvg_cmd_t            cmd,
    output sqvg_pkg::sqvg_status_t         status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [1:0]                     out_corner,
    output logic signed [15:0]             out_vertex_x,
    output logic signed [15:0]             out_vertex_y,
    output logic [sqvg_pkg::UV_W-1:0]      out_tex_u,
    output logic [sqvg_pkg::UV_W-1:0]      out_tex_v,
    output logic                           out_last
);

    localparam int IW  = $clog2(MAX_FRAMES);
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int DW  = (CW > 9) ? CW : 9;
    localparam int NW  = sqvg_pkg::DIV_NW;
    localparam int SW  = sqvg_pkg::SUM_W;
    localparam int FS  = sqvg_pkg::FRAC_SHIFT;
    localparam int UVW = sqvg_pkg::UV_W;
    localparam int AB  = sqvg_pkg::ANGLE_BITS;

    // configuration
    logic [11:0] width_reg, height_reg;
    logic [8:0]  across_reg, down_reg;
    logic [12:0] count_reg;
    logic        enable_reg;
    logic [15:0] hold_reg;

    // animation and atlas
    logic [15:0]   hc_reg;
    logic [IW-1:0] fi_reg;
    logic          dirty_reg;
    logic [IW-1:0] q_reg;
    logic [7:0]    col_reg, row_reg;
    logic [UVW-1:0] u0_reg, u1_reg, v0_reg, v1_reg;

    // item and geometry
    logic signed [15:0] cx_reg, cy_reg;
    logic [AB-1:0]      ang_reg;
    logic               adv_reg;
    logic signed [15:0] s_reg, c_reg;
    logic signed [31:0] pa_reg, pb_reg, pc_reg, pd_reg;

    logic [8:0]    across_eff, down_eff;
    logic [CW-1:0] count_eff;
    logic [15:0]   hold_eff;
    logic          cfg_hit;

    assign across_eff = (across_reg == '0) ? 9'd1 :
                        (across_reg > 9'(sqvg_pkg::ATLAS_MAX)) ? 9'(sqvg_pkg::ATLAS_MAX) :
                        across_reg;
    assign down_eff   = (down_reg == '0) ? 9'd1 :
                        (down_reg > 9'(sqvg_pkg::ATLAS_MAX)) ? 9'(sqvg_pkg::ATLAS_MAX) :
                        down_reg;
    assign count_eff  = (count_reg == '0) ? CW'(1) :
                        (32'(count_reg) > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) :
                        CW'(count_reg);
    assign hold_eff   = (hold_reg == '0) ? 16'd1 : hold_reg;
    assign cfg_hit    = cfg_wr_en && (cfg_index <= sqvg_pkg::REG_FRAME_HOLD);

    assign status.step_due = adv_reg && enable_reg &&
                             ((17'(hc_reg) + 17'd1) >= 17'(hold_eff));
    assign status.uv_dirty = dirty_reg;
    assign status.out_busy = out_valid && !out_ready;

    // divider operand selection
    logic [NW-1:0] dvd;
    logic [DW-1:0] dvs;
    logic [NW-1:0] quo;
    logic [DW-1:0] rem;
    logic          div_done;

    always_comb
    begin
        case (cmd.div_op)
            sqvg_pkg::DIV_STEP: begin dvd = NW'(fi_reg) + NW'(1); dvs = DW'(count_eff); end
            sqvg_pkg::DIV_COLQ: begin dvd = NW'(fi_reg);          dvs = DW'(across_eff); end
            sqvg_pkg::DIV_ROW:  begin dvd = NW'(q_reg);           dvs = DW'(down_eff); end
            sqvg_pkg::DIV_U0:   begin dvd = NW'({col_reg, 16'h0}); dvs = DW'(across_eff); end
            sqvg_pkg::DIV_U1:
            begin
                dvd = NW'({9'(col_reg) + 9'd1, 16'h0});
                dvs = DW'(across_eff);
            end
            sqvg_pkg::DIV_V0:   begin dvd = NW'({row_reg, 16'h0}); dvs = DW'(down_eff); end
            sqvg_pkg::DIV_V1:
            begin
                dvd = NW'({9'(row_reg) + 9'd1, 16'h0});
                dvs = DW'(down_eff);
            end
            default:            begin dvd = '0;                   dvs = DW'(1); end
        endcase
    end

    sqvg_divider #(.NW(NW), .DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    assign status.div_done = div_done;

    // sine lookup, quarter wave mirrored
    logic [AB-1:0]      ang_sel;
    logic [1:0]         quad;
    logic [AB-3:0]      r_low;
    logic [AB-2:0]      r_idx;
    logic [14:0]        mag;
    logic signed [15:0] trig_val;

    assign ang_sel  = cmd.trig_cos ? (ang_reg + AB'(sqvg_pkg::QUARTER_N)) : ang_reg;
    assign quad     = ang_sel[AB-1:AB-2];
    assign r_low    = ang_sel[AB-3:0];
    assign r_idx    = quad[0] ? ((AB-1)'(sqvg_pkg::QUARTER_N) - (AB-1)'(r_low))
                              : (AB-1)'(r_low);
    assign mag      = sqvg_pkg::SINE_TABLE[r_idx];
    assign trig_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // shared multiplier
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] prod;

    always_comb
    begin
        case (cmd.mul_idx)
            2'd0:    begin mul_a = $signed({1'b0, width_reg, 3'b0});  mul_b = c_reg; end
            2'd1:    begin mul_a = $signed({1'b0, height_reg, 3'b0}); mul_b = s_reg; end
            2'd2:    begin mul_a = $signed({1'b0, width_reg, 3'b0});  mul_b = s_reg; end
            default: begin mul_a = $signed({1'b0, height_reg, 3'b0}); mul_b = c_reg; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // corner sums: A=hw*c, B=hh*s, C=hw*s, D=hh*c
    logic signed [SW-1:0] base_x, base_y, ea, eb, ec, ed, sum_x, sum_y;
    logic signed [SW-FS-1:0] fl_x, fl_y;
    logic signed [15:0] sat_x, sat_y;

    assign base_x = SW'(cx_reg) <<< FS;
    assign base_y = SW'(cy_reg) <<< FS;
    assign ea     = SW'(pa_reg);
    assign eb     = SW'(pb_reg);
    assign ec     = SW'(pc_reg);
    assign ed     = SW'(pd_reg);
    assign sum_x  = base_x + (cmd.corner[0] ? ea : -ea) + (cmd.corner[1] ? eb : -eb);
    assign sum_y  = base_y + (cmd.corner[0] ? -ec : ec) + (cmd.corner[1] ? ed : -ed);
    assign fl_x   = sum_x[SW-1:FS];
    assign fl_y   = sum_y[SW-1:FS];
    assign sat_x  = (fl_x > (SW-FS)'(32767)) ? 16'sh7FFF :
                    (fl_x < -(SW-FS)'(32768)) ? -16'sh8000 : fl_x[15:0];
    assign sat_y  = (fl_y > (SW-FS)'(32767)) ? 16'sh7FFF :
                    (fl_y < -(SW-FS)'(32768)) ? -16'sh8000 : fl_y[15:0];

    // control-bearing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            across_reg <= 9'd1;
            down_reg   <= 9'd1;
            count_reg  <= 13'd1;
            enable_reg <= 1'b0;
            hold_reg   <= 16'd1;
            hc_reg     <= '0;
            fi_reg     <= '0;
            dirty_reg  <= 1'b1;
            out_valid  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    sqvg_pkg::REG_SPRITE_WIDTH:  width_reg  <= cfg_data[11:0];
                    sqvg_pkg::REG_SPRITE_HEIGHT: height_reg <= cfg_data[11:0];
                    sqvg_pkg::REG_FRAMES_ACROSS: across_reg <= cfg_data[8:0];
                    sqvg_pkg::REG_FRAMES_DOWN:   down_reg   <= cfg_data[8:0];
                    sqvg_pkg::REG_FRAME_COUNT:   count_reg  <= cfg_data[12:0];
                    sqvg_pkg::REG_ANIM_ENABLE:   enable_reg <= cfg_data[0];
                    sqvg_pkg::REG_FRAME_HOLD:    hold_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cfg_hit)
            begin
                hc_reg    <= '0;
                dirty_reg <= 1'b1;
            end
            else if (cmd.tick && adv_reg && enable_reg)
                hc_reg <= status.step_due ? 16'd0 : hc_reg + 16'd1;

            if (cmd.div_capture && cmd.div_op == sqvg_pkg::DIV_STEP)
            begin
                fi_reg    <= rem[IW-1:0];
                dirty_reg <= 1'b1;
            end
            else if (cmd.div_capture && cmd.div_op == sqvg_pkg::DIV_V1)
                dirty_reg <= 1'b0;

            if (cmd.emit)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            ang_reg <= angle[AB-1:0];
            adv_reg <= advance;
        end
        if (cmd.div_capture)
        begin
            case (cmd.div_op)
                sqvg_pkg::DIV_COLQ:
                begin
                    col_reg <= rem[7:0];
                    q_reg   <= quo[IW-1:0];
                end
                sqvg_pkg::DIV_ROW: row_reg <= rem[7:0];
                sqvg_pkg::DIV_U0:  u0_reg  <= quo[UVW-1:0];
                sqvg_pkg::DIV_U1:  u1_reg  <= quo[UVW-1:0];
                sqvg_pkg::DIV_V0:  v0_reg  <= quo[UVW-1:0];
                sqvg_pkg::DIV_V1:  v1_reg  <= quo[UVW-1:0];
                default: ;
            endcase
        end
        if (cmd.trig_load)
        begin
            if (cmd.trig_cos)
                c_reg <= trig_val;
            else
                s_reg <= trig_val;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_idx)
                2'd0:    pa_reg <= prod;
                2'd1:    pb_reg <= prod;
                2'd2:    pc_reg <= prod;
                default: pd_reg <= prod;
            endcase
        end
        if (cmd.emit)
        begin
            out_corner   <= cmd.corner;
            out_vertex_x <= sat_x;
            out_vertex_y <= sat_y;
            out_tex_u    <= cmd.corner[0] ? u1_reg : u0_reg;
            out_tex_v    <= cmd.corner[1] ? v1_reg : v0_reg;
            out_last     <= (cmd.corner == 2'd3);
        end
    end

endmodule

FILE: hdl/sqvg_ctrl.sv
// Controller: sequences tick, divisions, sine lookups, products and corner output.
module sqvg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sqvg_pkg::sqvg_status_t status,
    output sqvg_pkg::sqvg_cmd_t    cmd
);

    sqvg_pkg::ctrl_state_t state_reg, state_next;
    sqvg_pkg::div_op_t     op_reg, op_next;
    logic [1:0]            cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqvg_pkg::ST_IDLE;
            op_reg    <= sqvg_pkg::DIV_STEP;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.div_op = op_reg;
        cmd.mul_idx = cnt_reg;
        cmd.corner  = cnt_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            sqvg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sqvg_pkg::ST_TICK;
                end
            end
            sqvg_pkg::ST_TICK:
            begin
                cmd.tick = 1'b1;
                if (status.step_due)
                begin
                    op_next    = sqvg_pkg::DIV_STEP;
                    state_next = sqvg_pkg::ST_DIV_START;
                end
                else if (status.uv_dirty)
                begin
                    op_next    = sqvg_pkg::DIV_COLQ;
                    state_next = sqvg_pkg::ST_DIV_START;
                end
                else
                    state_next = sqvg_pkg::ST_SIN;
            end
            sqvg_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = sqvg_pkg::ST_DIV_WAIT;
            end
            sqvg_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = sqvg_pkg::ST_DIV_START;
                    unique case (op_reg)
                        sqvg_pkg::DIV_STEP: op_next = sqvg_pkg::DIV_COLQ;
                        sqvg_pkg::DIV_COLQ: op_next = sqvg_pkg::DIV_ROW;
                        sqvg_pkg::DIV_ROW:  op_next = sqvg_pkg::DIV_U0;
                        sqvg_pkg::DIV_U0:   op_next = sqvg_pkg::DIV_U1;
                        sqvg_pkg::DIV_U1:   op_next = sqvg_pkg::DIV_V0;
                        sqvg_pkg::DIV_V0:   op_next = sqvg_pkg::DIV_V1;
                        default:            state_next = sqvg_pkg::ST_SIN;
                    endcase
                end
            end
            sqvg_pkg::ST_SIN:
            begin
                cmd.trig_load = 1'b1;
                state_next    = sqvg_pkg::ST_COS;
            end
            sqvg_pkg::ST_COS:
            begin
                cmd.trig_load = 1'b1;
                cmd.trig_cos  = 1'b1;
                cnt_next      = '0;
                state_next    = sqvg_pkg::ST_MUL;
            end
            sqvg_pkg::ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = sqvg_pkg::ST_CORNER;
            end
            sqvg_pkg::ST_CORNER:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                        state_next = sqvg_pkg::ST_IDLE;
                end
            end
            default: state_next = sqvg_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: hdl/sqvg_checker.sv
// Port-level checks for the sprite quad vertex generator, bound to the top level.
module sqvg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed under stall");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'b11)))
        else $error("tlast not on the fourth corner");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

endmodule

bind sprite_quad_vertex_generator sqvg_checker u_sqvg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
